/* sv/assert_macros.svh */
// Concurrent assertion macros used by the converter top level.
// No dependencies; compiled to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/itp_pkg.sv */
// Package for the infix to postfix converter: sizes, item structs, operator
// kinds, error codes, character tables and helper functions. No dependencies.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        K_LPAR  = 3'd0,
        K_PLUS  = 3'd1,
        K_MINUS = 3'd2,
        K_MUL   = 3'd3,
        K_DIV   = 3'd4
    } t_kind;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] token;
        logic [1:0] error_code;
        logic       last_of_run;
    } t_out_item;

    function automatic logic [7:0] kind_char(input t_kind k);
        logic [7:0] c;
        unique case (k)
            K_LPAR:  c = CH_LPAR;
            K_PLUS:  c = CH_PLUS;
            K_MINUS: c = CH_MINUS;
            K_MUL:   c = CH_MUL;
            K_DIV:   c = CH_DIV;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] kind_rank(input t_kind k);
        logic [1:0] r;
        unique case (k)
            K_PLUS, K_MINUS: r = 2'd1;
            K_MUL, K_DIV:    r = 2'd2;
            default:         r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/itp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/infix_to_postfix_converter_unit.sv */
// Infix to postfix converter top level (shunting-yard on a memory stack).
// Depends on itp_pkg, itp_ram and assert_macros.svh.
//
// One character item is taken at a time; the input stalls until all results
// of that item have been handed to the output register. An item that pops
// nothing passes through accept, execute, flush check and finish. Each popped
// entry adds a pop step and a reload of the cached top of stack from the
// stack RAM, whose read data is registered; the reload is skipped when the
// pop empties the stack. The pop of the '(' that matches a ')' leaves the
// execute step at once, so it adds only its reload, if any. The last result
// of each item is held back in a pending register so that last_of_run can be
// set; output stalls hold any step that emits a result.
`include "assert_macros.svh"

module infix_to_postfix_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  itp_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output itp_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);
    import itp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TAIL, S_LOAD, S_DONE} t_state;
    typedef enum logic [2:0] {C_OPERAND, C_SPACE, C_OP, C_LPAR, C_RPAR} t_cls;

    t_state r_state, n_state, r_ret, n_ret;
    t_cls   r_cls, n_cls;
    t_kind  r_kind, n_kind, r_top, n_top;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic [CNT_W-1:0] r_count, n_count;
    t_out_item  r_pend, n_pend, r_out, n_out;
    logic       r_pend_v, n_pend_v, r_out_valid, n_out_valid;

    logic out_free, can_emit, emit, pop, push, fin, full;
    logic [7:0] e_tok;
    logic [1:0] e_err;
    t_state pop_ret;
    logic [CNT_W-1:0] rd_idx;
    logic [2:0] rdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign can_emit = !r_pend_v || out_free;
    assign full     = (r_count >= CNT_W'(STACK_DEPTH));
    assign rd_idx   = r_count - CNT_W'(2);

    itp_ram #(
        .WIDTH(3),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_count[STACK_AW-1:0]),
        .i_wdata (r_kind),
        .i_raddr (rd_idx[STACK_AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cls    = r_cls;
        n_kind   = r_kind;
        n_top    = r_top;
        n_char   = r_char;
        n_last   = r_last;
        n_count  = r_count;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        emit     = 1'b0;
        pop      = 1'b0;
        push     = 1'b0;
        fin      = 1'b0;
        e_tok    = 8'd0;
        e_err    = ERR_NONE;
        pop_ret  = S_EXEC;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char  = i_in_item.char_code;
                    n_last  = i_in_item.end_of_expr;
                    n_state = S_EXEC;
                    n_kind  = K_LPAR;
                    unique case (i_in_item.char_code)
                        CH_PLUS:  begin n_cls = C_OP; n_kind = K_PLUS;  end
                        CH_MINUS: begin n_cls = C_OP; n_kind = K_MINUS; end
                        CH_MUL:   begin n_cls = C_OP; n_kind = K_MUL;   end
                        CH_DIV:   begin n_cls = C_OP; n_kind = K_DIV;   end
                        CH_LPAR:  n_cls = C_LPAR;
                        CH_RPAR:  n_cls = C_RPAR;
                        CH_SPACE: n_cls = C_SPACE;
                        default:  n_cls = C_OPERAND;
                    endcase
                end
            end
            S_EXEC: begin
                unique case (r_cls)
                    C_SPACE: n_state = S_TAIL;
                    C_OPERAND: begin
                        if (can_emit) begin
                            emit    = 1'b1;
                            e_tok   = r_char;
                            n_state = S_TAIL;
                        end
                    end
                    C_OP, C_LPAR: begin
                        if (r_cls == C_OP && r_count != '0
                            && kind_rank(r_top) >= kind_rank(r_kind)) begin
                            if (can_emit) begin
                                emit    = 1'b1;
                                e_tok   = kind_char(r_top);
                                pop     = 1'b1;
                                pop_ret = S_EXEC;
                            end
                        end else if (full) begin
                            if (can_emit) begin
                                emit    = 1'b1;
                                e_err   = ERR_OVERFLOW;
                                n_state = S_TAIL;
                            end
                        end else begin
                            push    = 1'b1;
                            n_state = S_TAIL;
                        end
                    end
                    C_RPAR: begin
                        if (r_count == '0) begin
                            if (can_emit) begin
                                emit    = 1'b1;
                                e_err   = ERR_UNMATCHED;
                                n_state = S_TAIL;
                            end
                        end else if (r_top == K_LPAR) begin
                            pop     = 1'b1;
                            pop_ret = S_TAIL;
                        end else if (can_emit) begin
                            emit    = 1'b1;
                            e_tok   = kind_char(r_top);
                            pop     = 1'b1;
                            pop_ret = S_EXEC;
                        end
                    end
                    default: n_state = S_TAIL;
                endcase
            end
            S_TAIL: begin
                if (r_last && r_count != '0) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        pop     = 1'b1;
                        pop_ret = S_TAIL;
                        if (r_top == K_LPAR) begin
                            e_err = ERR_UNCLOSED;
                        end else begin
                            e_tok = kind_char(r_top);
                        end
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                n_top   = t_kind'(rdata);
                n_state = r_ret;
            end
            S_DONE: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push) begin
            n_top   = r_kind;
            n_count = r_count + CNT_W'(1);
        end
        if (pop) begin
            n_count = r_count - CNT_W'(1);
            n_ret   = pop_ret;
            n_state = (n_count == '0) ? pop_ret : S_LOAD;
        end
        if (emit) begin
            if (r_pend_v) begin
                n_out             = r_pend;
                n_out.last_of_run = 1'b0;
            end
            n_pend.token       = e_tok;
            n_pend.error_code  = e_err;
            n_pend.last_of_run = 1'b0;
            n_pend_v           = 1'b1;
        end
        if (fin) begin
            n_out             = r_pend;
            n_out.last_of_run = 1'b1;
            n_pend_v          = 1'b0;
        end
        n_out_valid = ((emit && r_pend_v) || fin) ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_count     <= n_count;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            r_cls       <= n_cls;
            r_kind      <= n_kind;
            r_top       <= n_top;
            r_char      <= n_char;
            r_last      <= n_last;
            r_pend      <= n_pend;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `ASSERT_IMPLY(a_err_token_zero, i_clk, i_rst_n,
                  o_out_valid && o_out_item.error_code != ERR_NONE, o_out_item.token == 8'd0)
    `ASSERT_NEXT(a_finish_marks_last, i_clk, i_rst_n, r_state == S_DONE && r_pend_v && out_free,
                 o_out_valid && o_out_item.last_of_run && !r_pend_v)
endmodule
